@@ rtl/assert_macros.svh @@
// assertion macros used by chacha20_stream_cipher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/chacha_pkg.sv @@
// package with constants and types of the chacha20 stream cipher
package chacha_pkg;

  localparam int unsigned DoubleRounds = 10;
  localparam int unsigned NumRounds = 2 * DoubleRounds;
  // one quarter-round step per cycle, four steps per round
  localparam int unsigned NumSteps = 4 * NumRounds;
  localparam int unsigned StepW = $clog2(NumSteps + 1);

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  localparam logic [2:0] RegKey01 = 3'd0;
  localparam logic [2:0] RegKey23 = 3'd1;
  localparam logic [2:0] RegKey45 = 3'd2;
  localparam logic [2:0] RegKey67 = 3'd3;
  localparam logic [2:0] RegNonce01 = 3'd4;
  localparam logic [2:0] RegNonce2 = 3'd5;
  localparam logic [2:0] RegStartCtr = 3'd6;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StOut
  } state_e;

  typedef logic [31:0] word_t;

  // quarter-round step selector passed to the cells
  typedef struct packed {
    logic       load;
    logic [1:0] phase;
    logic       shift;
  } cell_ctrl_t;

  function automatic word_t rotl(word_t v, int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

endpackage

@@ rtl/chacha_col_cell.sv @@
// one column cell: holds words a,b,c,d of one column, does one quarter-round step a cycle
module chacha_col_cell import chacha_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  word_t      init_a_i,
  input  word_t      init_b_i,
  input  word_t      init_c_i,
  input  word_t      init_d_i,
  // words handed in from the neighbor cells for the lane shuffles
  input  word_t      nb_b_i,
  input  word_t      nc_c_i,
  input  word_t      nd_d_i,
  output word_t      a_o,
  output word_t      b_o,
  output word_t      c_o,
  output word_t      d_o
);

  word_t a_q, b_q, c_q, d_q;
  word_t a_d, b_d, c_d, d_d;
  word_t sum_ab, sum_cd;

  assign sum_ab = a_q + b_q;
  assign sum_cd = c_q + d_q;

  // load, one of the four add-xor-rotate steps, or a lane shuffle
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    if (ctrl_i.load) begin
      a_d = init_a_i;
      b_d = init_b_i;
      c_d = init_c_i;
      d_d = init_d_i;
    end else if (ctrl_i.shift) begin
      b_d = nb_b_i;
      c_d = nc_c_i;
      d_d = nd_d_i;
    end else begin
      case (ctrl_i.phase)
        2'd0: begin
          a_d = sum_ab;
          d_d = rotl(d_q ^ sum_ab, 16);
        end
        2'd1: begin
          c_d = sum_cd;
          b_d = rotl(b_q ^ sum_cd, 12);
        end
        2'd2: begin
          a_d = sum_ab;
          d_d = rotl(d_q ^ sum_ab, 8);
        end
        default: begin
          c_d = sum_cd;
          b_d = rotl(b_q ^ sum_cd, 7);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign c_o = c_q;
  assign d_o = d_q;

endmodule

@@ rtl/chacha_core.sv @@
// chain of four column cells with round sequencer and final addition
module chacha_core import chacha_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  word_t [15:0] init_i,
  output logic         done_o,
  output word_t [15:0] ks_o
);

  // round steps: 4 quarter-round phases, then a lane shuffle
  localparam int unsigned RoundCyc = 5;
  localparam int unsigned TotCyc = RoundCyc * NumRounds;
  localparam int unsigned CntW = $clog2(TotCyc + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [2:0]      sub_q, sub_d;
  logic            diag_q, diag_d;
  cell_ctrl_t      ctrl;
  word_t [3:0]     a, b, c, d;
  word_t [15:0]    init_q;

  // sequencer, done flagged once the last shuffle has put the cells back in column order
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    sub_d  = sub_q;
    diag_d = diag_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sub_d  = '0;
      diag_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CntW'(1);
      if (sub_q == 3'd4) begin
        sub_d  = '0;
        diag_d = !diag_q;
      end else begin
        sub_d = sub_q + 3'd1;
      end
      if (cnt_q == CntW'(TotCyc - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      sub_q  <= '0;
      diag_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      sub_q  <= sub_d;
      diag_q <= diag_d;
    end
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      init_q <= init_i;
    end
  end

  assign ctrl.load  = start_i;
  assign ctrl.phase = sub_q[1:0];
  assign ctrl.shift = busy_q && (sub_q == 3'd4);

  // shuffle: into diagonal form rotate b by 1, c by 2, d by 3; back the reverse
  for (genvar i = 0; i < 4; i++) begin : g_cell
    chacha_col_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .init_a_i (init_i[i]),
      .init_b_i (init_i[4 + i]),
      .init_c_i (init_i[8 + i]),
      .init_d_i (init_i[12 + i]),
      .nb_b_i   (diag_q ? b[(i + 3) % 4] : b[(i + 1) % 4]),
      .nc_c_i   (c[(i + 2) % 4]),
      .nd_d_i   (diag_q ? d[(i + 1) % 4] : d[(i + 3) % 4]),
      .a_o      (a[i]),
      .b_o      (b[i]),
      .c_o      (c[i]),
      .d_o      (d[i])
    );
    assign ks_o[i]      = a[i] + init_q[i];
    assign ks_o[4 + i]  = b[i] + init_q[4 + i];
    assign ks_o[8 + i]  = c[i] + init_q[8 + i];
    assign ks_o[12 + i] = d[i] + init_q[12 + i];
  end

endmodule

@@ rtl/chacha20_stream_cipher.sv @@
// chacha20 stream cipher: xors each message byte with the keystream
// Each transaction carries one message byte. The first byte of every 64-byte
// block waits while the block function is started, a row of four column
// cells does one quarter-round step per cycle plus one lane shuffle per
// round, and the keystream is stored; the other 63 bytes of the block use
// the stored keystream and are taken back to back unless the output stalls.
// in_last ends the message: the byte position clears, the block counter
// reloads from start_counter and the next byte again waits for a new block.
module chacha20_stream_cipher import chacha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast    // out_last
);

`include "assert_macros.svh"

  logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce01_q;
  logic [31:0] nonce2_q, start_q;
  logic [31:0] ctr_q, ctr_d;
  logic [5:0]  pos_q, pos_d;
  word_t [15:0] ks_q, ks_core, init;
  state_e state_q, state_d;
  logic core_start, core_done;
  logic out_v_q, out_v_d;
  logic [7:0] out_b_q, ks_byte;
  logic out_l_q;
  logic take;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q <= '0; key23_q <= '0; key45_q <= '0; key67_q <= '0;
      nonce01_q <= '0; nonce2_q <= '0; start_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKey01:    key01_q   <= cfg_data_i;
        RegKey23:    key23_q   <= cfg_data_i;
        RegKey45:    key45_q   <= cfg_data_i;
        RegKey67:    key67_q   <= cfg_data_i;
        RegNonce01:  nonce01_q <= cfg_data_i;
        RegNonce2:   nonce2_q  <= cfg_data_i[31:0];
        RegStartCtr: start_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign init = {nonce2_q, nonce01_q[63:32], nonce01_q[31:0], ctr_q,
                 key67_q[63:32], key67_q[31:0], key45_q[63:32], key45_q[31:0],
                 key23_q[63:32], key23_q[31:0], key01_q[63:32], key01_q[31:0],
                 Sigma3, Sigma2, Sigma1, Sigma0};

  chacha_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .init_i  (init),
    .done_o  (core_done),
    .ks_o    (ks_core)
  );

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      ks_q <= ks_core;
    end
  end

  assign ks_byte = ks_q[pos_q[5:2]][8 * pos_q[1:0] +: 8];
  assign take = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StOut) && (!out_v_q || m_axis_tready);

  // block sequencing and byte position
  always_comb begin
    state_d    = state_q;
    core_start = 1'b0;
    pos_d      = pos_q;
    ctr_d      = ctr_q;
    out_v_d    = out_v_q && !m_axis_tready;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid && !cfg_we_i) begin
          core_start = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (core_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (take) begin
          out_v_d = 1'b1;
          if (s_axis_tlast) begin
            pos_d   = '0;
            ctr_d   = start_q;
            state_d = StIdle;
          end else begin
            pos_d = pos_q + 6'd1;
            if (pos_q == 6'd63) begin
              ctr_d   = ctr_q + 32'd1;
              state_d = StIdle;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase
    if (cfg_we_i && cfg_idx_i == RegStartCtr) begin
      ctr_d   = cfg_data_i[31:0];
      pos_d   = '0;
      state_d = StIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= '0;
      ctr_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      ctr_q   <= ctr_d;
      out_v_q <= out_v_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (take) begin
      out_b_q <= s_axis_tdata ^ ks_byte;
      out_l_q <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_b_q;
  assign m_axis_tlast  = out_l_q;

  `ASSERT_ALWAYS(a_no_take_outside_out, !take || state_q == StOut, "input taken while busy")
  `ASSERT_NEXT(a_last_resets_pos, take && s_axis_tlast && !cfg_we_i, pos_q == 6'd0, "pos not clear")
  `ASSERT_NEXT(a_take_gives_out, take, m_axis_tvalid, "result lost")

endmodule
